@@ hw/rtl/multi_ultrasonic_ranger_top_macros.svh @@
// Assertion macros for the multi-sensor ultrasonic ranger.
// Used by multi_ultrasonic_ranger_top; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef MULTI_ULTRASONIC_RANGER_TOP_MACROS_SVH
`define MULTI_ULTRASONIC_RANGER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define MUR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MUR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mur_pkg.sv @@
// Shared types and constants of the multi-sensor ultrasonic ranger.
// No dependencies; used by mur_dist, mur_ctrl and multi_ultrasonic_ranger_top.
package mur_pkg;

    localparam int MaxSensors = 8;

    localparam int CountW = 4;
    localparam int SettleW = 8;
    localparam int PulseW = 8;
    localparam int TimerW = 17;
    localparam int WidthW = 16;
    localparam int SensW = 3;
    localparam int DistW = 13;
    localparam int EchoW = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 17;

    // register indexes of the config port
    localparam logic [CfgIdxW-1:0] CFG_SENSOR_COUNT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE_US = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PULSE_US = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_US = 2'd3;

    // reset values of the config registers
    localparam logic [CountW-1:0] RST_SENSOR_COUNT = 4'd8;
    localparam logic [SettleW-1:0] RST_SETTLE_US = 8'd2;
    localparam logic [PulseW-1:0] RST_PULSE_US = 8'd14;
    localparam logic [TimerW-1:0] RST_TIMEOUT_US = 17'd100000;

    // cm = floor(half_width * 10 / 291) = (half_width * 4612300) >> 27
    // exact for half_width below 2^15
    localparam int RecipW = 23;
    localparam logic [RecipW-1:0] DIST_RECIP = 23'd4612300;
    localparam int DistShift = 27;
    localparam int ProdW = 38;
    localparam int DistCmW = 11;

    localparam logic signed [DistW-1:0] DIST_TIMEOUT = -13'sd1;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_SETTLE  = 5'b00010,
        PH_PULSE   = 5'b00100,
        PH_LISTEN  = 5'b01000,
        PH_MEASURE = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [CountW-1:0]  sensor_count;
        logic [SettleW-1:0] settle_us;
        logic [PulseW-1:0]  pulse_us;
        logic [TimerW-1:0]  timeout_us;
    } t_cfg;

    typedef struct packed {
        logic [SensW-1:0]        sensor_index;
        logic signed [DistW-1:0] distance_cm;
        logic                    done_res;
        logic                    busy_res;
        logic                    drive_enable;
        logic                    trigger_level;
    } t_result;

endpackage

@@ hw/rtl/mur_dist.sv @@
// Echo width to distance conversion: floor(floor(width/2)*10/291) cm.
// Depends on mur_pkg; one constant multiply, no divider.
module mur_dist (
    input  logic [mur_pkg::WidthW-1:0]  i_width,
    output logic [mur_pkg::DistCmW-1:0] o_dist_cm
);

    logic [mur_pkg::WidthW-2:0] half_w;
    logic [mur_pkg::ProdW-1:0]  prod;

    assign half_w = i_width[mur_pkg::WidthW-1:1];
    assign prod = mur_pkg::ProdW'(half_w) * mur_pkg::ProdW'(mur_pkg::DIST_RECIP);
    assign o_dist_cm = prod[mur_pkg::DistShift +: mur_pkg::DistCmW];

endmodule

@@ hw/rtl/mur_ctrl.sv @@
// Phase sequencer of the ranger: settle, pulse, listen and measure per tick.
// Depends on mur_pkg and mur_dist; state advances only on an accepted request.
module mur_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_cmd,
    input  logic [mur_pkg::EchoW-1:0]  i_echo,
    input  mur_pkg::t_cfg              i_cfg,
    output mur_pkg::t_result           o_result
);

    mur_pkg::t_phase                r_phase, n_phase;
    logic [mur_pkg::TimerW-1:0]     r_timer, n_timer;
    logic [mur_pkg::WidthW-1:0]     r_width, n_width;
    logic [mur_pkg::SensW-1:0]      r_sel, n_sel;

    logic [mur_pkg::DistCmW-1:0]    dist_cm;
    logic [mur_pkg::CountW-1:0]     n_active;
    logic [mur_pkg::EchoW-1:0]      hits;
    logic                           found;
    logic [mur_pkg::SensW-1:0]      first_idx;

    mur_dist u_dist (
        .i_width   (r_width),
        .o_dist_cm (dist_cm)
    );

    // sensors in use, clamped to the physical count
    assign n_active = (i_cfg.sensor_count > mur_pkg::CountW'(mur_pkg::MaxSensors))
                    ? mur_pkg::CountW'(mur_pkg::MaxSensors) : i_cfg.sensor_count;

    // lowest-index echo among sensors in use
    always_comb begin
        hits = '0;
        first_idx = '0;
        for (int i = 0; i < mur_pkg::EchoW; i++) begin
            hits[i] = i_echo[i] && (mur_pkg::CountW'(i) < n_active);
        end
        for (int i = mur_pkg::EchoW - 1; i >= 0; i--) begin
            if (hits[i]) begin
                first_idx = mur_pkg::SensW'(i);
            end
        end
    end
    assign found = |hits;

    always_comb begin
        mur_pkg::t_phase            cur;
        logic [mur_pkg::TimerW-1:0] tmr;
        logic [mur_pkg::TimerW-1:0] tmr_inc;
        logic                       is_idle;

        is_idle = !(r_phase == mur_pkg::PH_SETTLE || r_phase == mur_pkg::PH_PULSE ||
                    r_phase == mur_pkg::PH_LISTEN || r_phase == mur_pkg::PH_MEASURE);
        // start request lands on the first settle (or pulse) tick
        if (is_idle) begin
            tmr = '0;
            if (i_cmd) begin
                cur = (i_cfg.settle_us == '0) ? mur_pkg::PH_PULSE : mur_pkg::PH_SETTLE;
            end else begin
                cur = mur_pkg::PH_IDLE;
            end
        end else begin
            tmr = r_timer;
            cur = r_phase;
        end
        tmr_inc = tmr + 1'b1;

        n_phase = cur;
        n_timer = tmr;
        n_width = r_width;
        n_sel = r_sel;
        o_result = '0;

        unique case (cur)
            mur_pkg::PH_SETTLE: begin
                o_result.drive_enable = 1'b1;
                o_result.busy_res = 1'b1;
                n_timer = tmr_inc;
                if (tmr_inc >= mur_pkg::TimerW'(i_cfg.settle_us)) begin
                    n_phase = mur_pkg::PH_PULSE;
                    n_timer = '0;
                end
            end
            mur_pkg::PH_PULSE: begin
                o_result.trigger_level = 1'b1;
                o_result.drive_enable = 1'b1;
                o_result.busy_res = 1'b1;
                n_timer = tmr_inc;
                if (tmr_inc >= mur_pkg::TimerW'(i_cfg.pulse_us)) begin
                    n_phase = mur_pkg::PH_LISTEN;
                    n_timer = '0;
                    n_width = '0;
                end
            end
            mur_pkg::PH_LISTEN: begin
                // an echo wins over a timeout on the same tick
                if (found) begin
                    n_sel = first_idx;
                    n_width = mur_pkg::WidthW'(1);
                    n_phase = mur_pkg::PH_MEASURE;
                    o_result.busy_res = 1'b1;
                end else if (tmr_inc >= i_cfg.timeout_us || tmr_inc == '0) begin
                    o_result.done_res = 1'b1;
                    o_result.distance_cm = mur_pkg::DIST_TIMEOUT;
                    n_phase = mur_pkg::PH_IDLE;
                    n_timer = '0;
                end else begin
                    o_result.busy_res = 1'b1;
                    n_timer = tmr_inc;
                end
            end
            mur_pkg::PH_MEASURE: begin
                if (i_echo[r_sel]) begin
                    if (r_width != '1) begin
                        n_width = r_width + 1'b1;
                    end
                    o_result.busy_res = 1'b1;
                end else begin
                    o_result.done_res = 1'b1;
                    o_result.distance_cm = mur_pkg::DistW'(dist_cm);
                    o_result.sensor_index = r_sel;
                    n_phase = mur_pkg::PH_IDLE;
                    n_timer = '0;
                end
            end
            mur_pkg::PH_IDLE: begin
                n_phase = mur_pkg::PH_IDLE;
            end
            default: begin
                n_phase = mur_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mur_pkg::PH_IDLE;
            r_timer <= '0;
            r_width <= '0;
            r_sel <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_width <= n_width;
            r_sel <= n_sel;
        end
    end

endmodule

@@ hw/rtl/multi_ultrasonic_ranger_top.sv @@
// Top level of the multi-sensor ultrasonic ranger: config registers and output register.
// Depends on mur_pkg, mur_ctrl (with mur_dist) and multi_ultrasonic_ranger_top_macros.svh.
//
// Usage:
// - Input stream: one request per microsecond tick. tdata carries the sampled echo
//   pin levels, tuser the start flag. A start while a measurement runs is dropped.
// - Output stream: exactly one result per input request, giving the pin drive for
//   that tick, busy/done, and on done the distance in cm (-1 on timeout) and the
//   sensor measured (lowest-index echo among the sensors in use wins).
// - Latency: a result is presented the cycle after its request is taken.
// - Throughput: one request per cycle unless the output stalls; the path from the
//   state registers through the phase logic and the single constant multiply of
//   the cm conversion into the output register sets the clock, not the rate.
// - Stall: the output register holds its result while m_axis_tready is low; input
//   tready stays high whenever the output register is empty or being drained, so
//   a new tick is taken in the same cycle the pending result leaves.
// - Reset (synchronous, active low): phase idle, timers cleared, config registers
//   back to 8 sensors, 2 us settle, 14 us pulse, 100000 us timeout, output empty.
// - Config: write enable, index and data; the write takes effect at the clock edge.
`include "multi_ultrasonic_ranger_top_macros.svh"

module multi_ultrasonic_ranger_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] echo_levels
    input  logic                          s_axis_tuser,   // [0] cmd
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] trigger_level, [1] drive_enable, [2] busy_res, [3] done_res,
    // [16:4] distance_cm, [19:17] sensor_index, [23:20] zero
    output logic [23:0]                   m_axis_tdata,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [mur_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [mur_pkg::CfgDataW-1:0]  i_cfg_wdata
);

    mur_pkg::t_cfg    r_cfg;
    mur_pkg::t_result ctrl_result;
    mur_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;

    // output register may be refilled as soon as it is empty or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_count <= mur_pkg::RST_SENSOR_COUNT;
            r_cfg.settle_us <= mur_pkg::RST_SETTLE_US;
            r_cfg.pulse_us <= mur_pkg::RST_PULSE_US;
            r_cfg.timeout_us <= mur_pkg::RST_TIMEOUT_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mur_pkg::CFG_SENSOR_COUNT: begin
                    r_cfg.sensor_count <= i_cfg_wdata[mur_pkg::CountW-1:0];
                end
                mur_pkg::CFG_SETTLE_US: begin
                    r_cfg.settle_us <= i_cfg_wdata[mur_pkg::SettleW-1:0];
                end
                mur_pkg::CFG_PULSE_US: begin
                    r_cfg.pulse_us <= i_cfg_wdata[mur_pkg::PulseW-1:0];
                end
                mur_pkg::CFG_TIMEOUT_US: begin
                    r_cfg.timeout_us <= i_cfg_wdata[mur_pkg::TimerW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mur_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (s_axis_tuser),
        .i_echo   (s_axis_tdata),
        .i_cfg    (r_cfg),
        .o_result (ctrl_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= ctrl_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {4'b0000, r_out.sensor_index, r_out.distance_cm, r_out.done_res,
                           r_out.busy_res, r_out.drive_enable, r_out.trigger_level};

    // every taken tick shows up as a result on the next cycle
    `MUR_ASSERT_NEXT(a_result_follows, accept, r_out_valid, "no result after request")
    // a finished measurement never reports busy
    `MUR_ASSERT_NOW(a_done_not_busy, r_out_valid && r_out.done_res, !r_out.busy_res,
                    "done and busy together")
    // trigger high only while the pins are driven
    `MUR_ASSERT_NOW(a_trig_driven, r_out_valid && r_out.trigger_level, r_out.drive_enable,
                    "trigger high with pins released")
    // timeout results carry sensor zero
    `MUR_ASSERT_NOW(a_timeout_idx,
                    r_out_valid && r_out.distance_cm == mur_pkg::DIST_TIMEOUT,
                    r_out.done_res && r_out.sensor_index == '0,
                    "bad timeout result")

endmodule

@@ dv/tb_multi_ultrasonic_ranger_top.sv @@
// Self-checking testbench for multi_ultrasonic_ranger_top: drives microsecond ticks and
// checks every result against a tick-by-tick ranger model kept in this file.
// Depends on mur_pkg and the RTL of multi_ultrasonic_ranger_top only.
module tb_multi_ultrasonic_ranger_top;
    timeunit 1ns;
    timeprecision 1ps;

    // no accepted request or result for this many cycles ends the run
    localparam int STUCK_LIMIT = 4000;
    // length of the forced receiver hold-off that backs the block up
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       cmd;
        logic [7:0] echo;
    } t_tick_req;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;   // [7:0] echo_levels
    logic                         s_axis_tuser = 1'b0; // [0] cmd
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [0] trigger_level, [1] drive_enable, [2] busy_res, [3] done_res,
    // [16:4] distance_cm, [19:17] sensor_index, [23:20] zero
    logic [23:0]                  m_axis_tdata;
    logic                         i_cfg_we = 1'b0;
    logic [mur_pkg::CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [mur_pkg::CfgDataW-1:0] i_cfg_wdata = '0;

    multi_ultrasonic_ranger_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_tick_req        tick_queue[$];         // ticks waiting for the driver
    mur_pkg::t_result predicted_readings[$]; // one per accepted tick, oldest first

    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_seq = 0;         // bump to start one long receiver hold-off
    int         mismatch_count = 0;
    logic       in_fire = 1'b0;       // request taken at the last rising edge
    int         stuck_cycles = 0;

    // ranger model: config copy, reset values
    logic [mur_pkg::CountW-1:0]  c_count = mur_pkg::RST_SENSOR_COUNT;
    logic [mur_pkg::SettleW-1:0] c_settle = mur_pkg::RST_SETTLE_US;
    logic [mur_pkg::PulseW-1:0]  c_pulse = mur_pkg::RST_PULSE_US;
    logic [mur_pkg::TimerW-1:0]  c_timeout = mur_pkg::RST_TIMEOUT_US;

    // ranger model: measurement state
    mur_pkg::t_phase             p_phase = mur_pkg::PH_IDLE;
    logic [mur_pkg::TimerW-1:0]  p_timer = '0;
    logic [mur_pkg::WidthW-1:0]  p_width = '0;
    logic [mur_pkg::SensW-1:0]   p_sel = '0;

    // ------------------------------------------------------------------
    // Ranger model
    // ------------------------------------------------------------------

    // counts above the hardware limit clamp; zero watches nothing
    function automatic int unsigned watched_sensors();
        int unsigned n;
        n = c_count;
        if (n > mur_pkg::MaxSensors) n = mur_pkg::MaxSensors;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic logic [7:0] watch_mask();
        int unsigned n;
        n = watched_sensors();
        return (n >= 8) ? 8'hFF : 8'((32'd1 << n) - 1);
    endfunction

    // advance one microsecond and return the result for this tick
    function automatic mur_pkg::t_result advance_ranger(logic cmd, logic [7:0] echo);
        mur_pkg::t_result r;
        int unsigned      n;
        int unsigned      k;
        int unsigned      cm;
        bit               found;
        r = '0;
        found = 1'b0;
        // a start is only seen while idle; zero settle goes straight to the pulse
        if (p_phase == mur_pkg::PH_IDLE && cmd) begin
            p_timer = '0;
            p_phase = (c_settle == 0) ? mur_pkg::PH_PULSE : mur_pkg::PH_SETTLE;
        end
        case (p_phase)
            mur_pkg::PH_SETTLE: begin
                r.drive_enable = 1'b1;
                r.busy_res = 1'b1;
                p_timer = p_timer + 1'b1;
                if (p_timer >= c_settle) begin
                    p_phase = mur_pkg::PH_PULSE;
                    p_timer = '0;
                end
            end
            mur_pkg::PH_PULSE: begin
                r.trigger_level = 1'b1;
                r.drive_enable = 1'b1;
                r.busy_res = 1'b1;
                p_timer = p_timer + 1'b1;
                // zero pulse length ends after one tick too
                if (p_timer >= c_pulse) begin
                    p_phase = mur_pkg::PH_LISTEN;
                    p_timer = '0;
                    p_width = '0;
                end
            end
            mur_pkg::PH_LISTEN: begin
                n = watched_sensors();
                k = 0;
                while (k < n && !found) begin
                    if (echo[k]) found = 1'b1;
                    else k++;
                end
                // an echo wins over a timeout on the same tick
                if (found) begin
                    p_sel = mur_pkg::SensW'(k);
                    p_width = 16'd1;
                    p_phase = mur_pkg::PH_MEASURE;
                    r.busy_res = 1'b1;
                end else begin
                    p_timer = p_timer + 1'b1;
                    if (p_timer >= c_timeout || p_timer == 0) begin
                        r.done_res = 1'b1;
                        r.distance_cm = mur_pkg::DIST_TIMEOUT;
                        p_phase = mur_pkg::PH_IDLE;
                        p_timer = '0;
                    end else begin
                        r.busy_res = 1'b1;
                    end
                end
            end
            mur_pkg::PH_MEASURE: begin
                if (echo[p_sel]) begin
                    if (p_width != 16'hFFFF) p_width = p_width + 1'b1;
                    r.busy_res = 1'b1;
                end else begin
                    cm = ((int'(p_width) >> 1) * 10) / 291;
                    r.done_res = 1'b1;
                    r.distance_cm = mur_pkg::DistW'(cm);
                    r.sensor_index = p_sel;
                    p_phase = mur_pkg::PH_IDLE;
                    p_timer = '0;
                end
            end
            default: p_phase = mur_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) in_fire <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin : drive_blk
        t_tick_req t;
        int unsigned gap_pct;
        case (idle_mode)
            IDLE_SEND: gap_pct = 45;
            IDLE_BOTH: gap_pct = 35;
            default:   gap_pct = 0;
        endcase
        if (!s_axis_tvalid || in_fire) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                t = tick_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= t.echo;
                s_axis_tuser <= t.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : recv_blk
        int hold_seen;
        int hold_left;
        int unsigned stall_pct;
        case (idle_mode)
            IDLE_RECV: stall_pct = 45;
            IDLE_BOTH: stall_pct = 35;
            default:   stall_pct = 0;
        endcase
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare results first, then predict for the new request
    // (a result never leaves in the cycle its request is taken)
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, int got_v, int want_v);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got_v, want_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_blk
        mur_pkg::t_result got;
        mur_pkg::t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = mur_pkg::t_result'(m_axis_tdata[19:0]);
                if (predicted_readings.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(m_axis_tdata), 0);
                end else begin
                    want = predicted_readings.pop_front();
                    if (got.trigger_level !== want.trigger_level)
                        report_mismatch("trigger_level", got.trigger_level, want.trigger_level);
                    if (got.drive_enable !== want.drive_enable)
                        report_mismatch("drive_enable", got.drive_enable, want.drive_enable);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.distance_cm !== want.distance_cm)
                        report_mismatch("distance_cm", int'(got.distance_cm),
                                        int'(want.distance_cm));
                    if (got.sensor_index !== want.sensor_index)
                        report_mismatch("sensor_index", got.sensor_index, want.sensor_index);
                    if (m_axis_tdata[23:20] !== 4'b0)
                        report_mismatch("tdata pad", m_axis_tdata[23:20], 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_readings.push_back(advance_ranger(s_axis_tuser, s_axis_tdata));
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends a run in which nothing moves
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------
    task automatic push_tick(logic cmd, logic [7:0] echo);
        tick_queue.push_back('{cmd: cmd, echo: echo});
    endtask

    // a start now and then while busy; the block must drop it
    function automatic logic busy_cmd();
        return ($urandom_range(7) == 0);
    endfunction

    // start tick plus the rest of the settle and pulse ticks; echo is don't-care here
    task automatic push_trigger();
        int unsigned drive_n;
        drive_n = c_settle + ((c_pulse == 0) ? 1 : c_pulse);
        push_tick(1'b1, 8'($urandom));
        for (int unsigned k = 1; k < drive_n; k++) push_tick(busy_cmd(), 8'($urandom));
    endtask

    // full measurement: quiet listen ticks, then an echo of the given width on one sensor.
    // all_high puts every pin high so the lowest sensor must win.
    task automatic push_measure(int unsigned listen_n, int unsigned width,
                                int unsigned sensor, bit all_high);
        logic [7:0] watch;
        logic [7:0] sel_bit;
        logic [7:0] below;
        watch = watch_mask();
        sel_bit = 8'(32'd1 << sensor);
        below = sel_bit - 8'd1;
        push_trigger();
        // only unwatched pins may toggle while listening
        for (int unsigned k = 0; k < listen_n; k++)
            push_tick(busy_cmd(), 8'($urandom) & ~watch);
        // first echo tick: nothing lower than the chosen sensor may be high
        push_tick(busy_cmd(), all_high ? 8'hFF : ((8'($urandom) & ~below) | sel_bit));
        for (int unsigned k = 1; k < width; k++)
            push_tick(busy_cmd(), all_high ? 8'hFF : (8'($urandom) | sel_bit));
        push_tick(busy_cmd(), 8'($urandom) & ~sel_bit);
    endtask

    // no watched echo: runs into the timeout (zero acts as one tick)
    task automatic push_timeout();
        logic [7:0] watch;
        int unsigned wait_n;
        watch = watch_mask();
        wait_n = (c_timeout == 0) ? 1 : c_timeout;
        push_trigger();
        for (int unsigned k = 0; k < wait_n; k++)
            push_tick(busy_cmd(), 8'($urandom) & ~watch);
    endtask

    // mostly well-formed measurements, some timeouts and some raw noise
    task automatic random_phase(int unsigned seqs);
        int unsigned pick;
        int unsigned n;
        int unsigned lmax;
        int unsigned width;
        int unsigned noise_n;
        for (int unsigned s = 0; s < seqs; s++) begin
            pick = $urandom_range(99);
            n = watched_sensors();
            if ((n == 0 || pick < 15) && c_timeout <= 300) begin
                push_timeout();
            end else if (n == 0 || pick < 30) begin
                noise_n = $urandom_range(16, 4);
                for (int unsigned k = 0; k < noise_n; k++)
                    push_tick($urandom_range(3) == 0, 8'($urandom));
            end else begin
                lmax = (c_timeout > 1) ? ((c_timeout - 1 < 20) ? c_timeout - 1 : 20) : 0;
                width = ($urandom_range(7) == 0) ? $urandom_range(200, 60)
                                                 : $urandom_range(40, 1);
                push_measure($urandom_range(lmax), width, $urandom_range(n - 1), 1'b0);
            end
        end
    endtask

    // wait until every tick is sent and every result checked
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (tick_queue.size() != 0 || s_axis_tvalid || predicted_readings.size() != 0);
    endtask

    task automatic write_reg(logic [mur_pkg::CfgIdxW-1:0] idx,
                             logic [mur_pkg::CfgDataW-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        // model copy follows at once; nothing is accepted at this edge
        case (idx)
            mur_pkg::CFG_SENSOR_COUNT: c_count = value[mur_pkg::CountW-1:0];
            mur_pkg::CFG_SETTLE_US:    c_settle = value[mur_pkg::SettleW-1:0];
            mur_pkg::CFG_PULSE_US:     c_pulse = value[mur_pkg::PulseW-1:0];
            mur_pkg::CFG_TIMEOUT_US:   c_timeout = value[mur_pkg::TimerW-1:0];
            default: ;
        endcase
    endtask

    // drain, then rewrite all four registers and pick the idling pattern
    task automatic configure(int unsigned cnt, int unsigned settle, int unsigned pulse,
                             int unsigned tout, t_idle_mode mode);
        wait_quiet();
        write_reg(mur_pkg::CFG_SENSOR_COUNT, mur_pkg::CfgDataW'(cnt));
        write_reg(mur_pkg::CFG_SETTLE_US, mur_pkg::CfgDataW'(settle));
        write_reg(mur_pkg::CFG_PULSE_US, mur_pkg::CfgDataW'(pulse));
        write_reg(mur_pkg::CFG_TIMEOUT_US, mur_pkg::CfgDataW'(tout));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        idle_mode = mode;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: idle ticks ignore echo, then all pins high -> sensor 0 wins
        push_tick(1'b0, 8'hFF);
        push_tick(1'b0, 8'h00);
        push_measure(2, 3, 0, 1'b1);

        // shortest drive, highest sensor, one-tick echo, a timeout
        configure(8, 0, 1, 20, IDLE_NONE);
        push_measure(3, 20, 7, 1'b0);
        push_measure(0, 1, 0, 1'b1);
        push_timeout();
        random_phase(1);

        // longer settle and pulse, single sensor, shortest timeout
        configure(1, 12, 20, 1, IDLE_SEND);
        random_phase(2);

        // zero pulse length and zero timeout
        configure(3, 1, 0, 0, IDLE_RECV);
        random_phase(3);

        // no sensor watched: every measurement times out
        configure(0, 3, 2, 25, IDLE_BOTH);
        random_phase(3);

        // count above the limit, longest timeout
        configure(15, 2, 3, 131071, IDLE_BOTH);
        random_phase(2);

        // back-pressure: receiver holds off while the sender keeps offering
        configure(5, 1, 2, 60, IDLE_NONE);
        random_phase(2);
        hold_seq++;

        configure(2, 4, 5, 90, IDLE_SEND);
        random_phase(2);

        wait_quiet();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
